// ===== hw/rtl/integer_calculator_alu_assert.svh =====
// Assertion macros for the checker module of the calculator ALU.
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICALU_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("icalu: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ICALU_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("icalu: assertion failed");

`endif

// ===== hw/rtl/icalu_pkg.sv =====
package icalu_pkg;

	localparam int ICALU_DATA_WIDTH = 32;
	localparam int CMD_W = 4;

	localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DIV   = 4'd3;
	localparam logic [CMD_W-1:0] CMD_MAX   = 4'd4;
	localparam logic [CMD_W-1:0] CMD_PRIME = 4'd5;
	localparam logic [CMD_W-1:0] CMD_EVEN  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SIGN  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_FACT  = 4'd8;
	localparam logic [CMD_W-1:0] CMD_SQR   = 4'd9;
	localparam logic [CMD_W-1:0] CMD_PERIM = 4'd10;

	// Request to the serial multiply/divide unit.
	typedef struct packed {
		logic start;
		logic div;
	} md_ctl_t;

endpackage

// ===== hw/rtl/icalu_serial.sv =====
// Shared radix-2 unit: shift-add multiply (low half of the product) and
// restoring unsigned divide, one bit per cycle.
module icalu_serial #(
	parameter int DATA_WIDTH = icalu_pkg::ICALU_DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  icalu_pkg::md_ctl_t    ctl,
	input  logic [DATA_WIDTH-1:0] x,
	input  logic [DATA_WIDTH-1:0] y,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] prod,
	output logic [DATA_WIDTH-1:0] quot,
	output logic [DATA_WIDTH-1:0] rem
);
	import icalu_pkg::*;

	localparam int CW = $clog2(DATA_WIDTH + 1);

	logic                  busy_q;
	logic                  div_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] sh_q;
	logic [DATA_WIDTH-1:0] op_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH-1:0] acc_d;
	logic [DATA_WIDTH-1:0] sh_d;

	always_comb begin
		trial = {acc_q, sh_q[DATA_WIDTH-1]} - {1'b0, op_q};
		if (div_q) begin
			if (!trial[DATA_WIDTH]) begin
				acc_d = trial[DATA_WIDTH-1:0];
				sh_d  = {sh_q[DATA_WIDTH-2:0], 1'b1};
			end else begin
				acc_d = {acc_q[DATA_WIDTH-2:0], sh_q[DATA_WIDTH-1]};
				sh_d  = {sh_q[DATA_WIDTH-2:0], 1'b0};
			end
		end else begin
			acc_d = sh_q[0] ? acc_q + op_q : acc_q;
			sh_d  = sh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			div_q <= ctl.div;
			acc_q <= '0;
			sh_q  <= ctl.div ? x : y;
			op_q  <= ctl.div ? y : x;
		end else if (busy_q) begin
			acc_q <= acc_d;
			sh_q  <= sh_d;
			if (!div_q)
				op_q <= op_q << 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quot = sh_q;
	assign rem  = acc_q;

endmodule

// ===== hw/rtl/integer_calculator_alu.sv =====
// Add, sub, max, even, sign, perimeter, unused codes and divide by zero finish without the serial
// unit; mul, square and div make one multiply/divide pass through it. Prime and factorial run one
// multiply/divide pass per trial divisor or factor. One item is in work at a time: a new beat is
// taken only once the previous result has left for the output register, and it is taken while
// that result waits there. arst_n clears control and output valid.
module integer_calculator_alu #(
	parameter int DATA_WIDTH = icalu_pkg::ICALU_DATA_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [icalu_pkg::CMD_W-1:0]  cmd,
	input  logic [DATA_WIDTH-1:0]        operand_a,
	input  logic [DATA_WIDTH-1:0]        operand_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DATA_WIDTH-1:0]        result
);
	import icalu_pkg::*;

	localparam int SW = 3;
	localparam logic [SW-1:0] ST_IDLE  = 3'd0;
	localparam logic [SW-1:0] ST_DISP  = 3'd1;
	localparam logic [SW-1:0] ST_WAIT  = 3'd2;
	localparam logic [SW-1:0] ST_PCHK  = 3'd3;
	localparam logic [SW-1:0] ST_PWAIT = 3'd4;
	localparam logic [SW-1:0] ST_FCHK  = 3'd5;
	localparam logic [SW-1:0] ST_FWAIT = 3'd6;
	localparam logic [SW-1:0] ST_DONE  = 3'd7;

	localparam logic [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1);

	logic [SW-1:0]         state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH-1:0] sq_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic [DATA_WIDTH-1:0] result_q;
	logic                  out_valid_q;
	logic                  neg_q;
	logic                  load_out;

	md_ctl_t               md_ctl;
	logic [DATA_WIDTH-1:0] md_x;
	logic [DATA_WIDTH-1:0] md_y;
	logic                  md_done;
	logic [DATA_WIDTH-1:0] md_prod;
	logic [DATA_WIDTH-1:0] md_quot;
	logic [DATA_WIDTH-1:0] md_rem;

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;

	assign mag_a = a_q[DATA_WIDTH-1] ? -a_q : a_q;
	assign mag_b = b_q[DATA_WIDTH-1] ? -b_q : b_q;

	// A finished result moves to the output register once that register is free or drains.
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		md_ctl = '0;
		md_x   = a_q;
		md_y   = b_q;
		unique case (state_q)
			ST_DISP: begin
				if (cmd_q == CMD_MUL) begin
					md_ctl.start = 1'b1;
				end else if (cmd_q == CMD_SQR) begin
					md_ctl.start = 1'b1;
					md_y = a_q;
				end else if (cmd_q == CMD_DIV && b_q != '0) begin
					md_ctl.start = 1'b1;
					md_ctl.div = 1'b1;
					md_x = mag_a;
					md_y = mag_b;
				end
			end
			ST_PCHK: begin
				md_y = d_q;
				if (sq_q <= a_q) begin
					md_ctl.start = 1'b1;
					md_ctl.div = 1'b1;
				end
			end
			ST_FCHK: begin
				md_x = res_q;
				md_y = d_q;
				md_ctl.start = (d_q <= a_q);
			end
			default: begin
			end
		endcase
	end

	icalu_serial #(.DATA_WIDTH(DATA_WIDTH)) u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (md_ctl),
		.x      (md_x),
		.y      (md_y),
		.done   (md_done),
		.prod   (md_prod),
		.quot   (md_quot),
		.rem    (md_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_DISP;
				end
				ST_DISP: begin
					unique case (cmd_q)
						CMD_MUL, CMD_SQR: state_q <= ST_WAIT;
						CMD_DIV: state_q <= (b_q != '0) ? ST_WAIT : ST_DONE;
						CMD_PRIME: begin
							if (a_q[DATA_WIDTH-1] || a_q < DATA_WIDTH'(4))
								state_q <= ST_DONE;
							else
								state_q <= ST_PCHK;
						end
						CMD_FACT: state_q <= a_q[DATA_WIDTH-1] ? ST_DONE : ST_FCHK;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_WAIT: begin
					if (md_done)
						state_q <= ST_DONE;
				end
				ST_PCHK: state_q <= (sq_q <= a_q) ? ST_PWAIT : ST_DONE;
				ST_PWAIT: begin
					if (md_done)
						state_q <= (md_rem == '0) ? ST_DONE : ST_PCHK;
				end
				ST_FCHK: state_q <= (d_q <= a_q) ? ST_FWAIT : ST_DONE;
				ST_FWAIT: begin
					if (md_done)
						state_q <= (md_prod == '0) ? ST_DONE : ST_FCHK;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd_q <= cmd;
					a_q   <= operand_a;
					b_q   <= operand_b;
				end
			end
			ST_DISP: begin
				neg_q <= a_q[DATA_WIDTH-1] ^ b_q[DATA_WIDTH-1];
				unique case (cmd_q)
					CMD_ADD: res_q <= a_q + b_q;
					CMD_SUB: res_q <= a_q - b_q;
					CMD_DIV: res_q <= '0;
					CMD_MAX: res_q <= ($signed(a_q) > $signed(b_q)) ? a_q : b_q;
					CMD_PRIME: begin
						res_q <= ONE;
						d_q   <= DATA_WIDTH'(2);
						sq_q  <= DATA_WIDTH'(4);
					end
					CMD_EVEN: res_q <= a_q[0] ? '0 : ONE;
					CMD_SIGN: begin
						if (a_q == '0)
							res_q <= '1;
						else
							res_q <= a_q[DATA_WIDTH-1] ? '0 : ONE;
					end
					CMD_FACT: begin
						res_q <= a_q[DATA_WIDTH-1] ? '1 : ONE;
						d_q   <= DATA_WIDTH'(2);
					end
					CMD_PERIM: res_q <= a_q << 2;
					default: res_q <= '0;
				endcase
			end
			ST_WAIT: begin
				if (md_done) begin
					if (cmd_q == CMD_DIV)
						res_q <= neg_q ? -md_quot : md_quot;
					else
						res_q <= md_prod;
				end
			end
			ST_PWAIT: begin
				if (md_done) begin
					if (md_rem == '0) begin
						res_q <= '0;
					end else begin
						// (d + 1)^2 = d^2 + 2d + 1 keeps the bound check to one add.
						sq_q <= sq_q + {d_q[DATA_WIDTH-2:0], 1'b1};
						d_q  <= d_q + ONE;
					end
				end
			end
			ST_FWAIT: begin
				if (md_done) begin
					res_q <= md_prod;
					d_q   <= d_q + ONE;
				end
			end
			ST_DONE: begin
				if (load_out)
					result_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

// ===== hw/rtl/icalu_checker.sv =====
`include "integer_calculator_alu_assert.svh"

module icalu_checker #(
	parameter int DATA_WIDTH = icalu_pkg::ICALU_DATA_WIDTH
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [icalu_pkg::CMD_W-1:0] cmd,
	input logic [DATA_WIDTH-1:0]       operand_a,
	input logic [DATA_WIDTH-1:0]       operand_b,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [DATA_WIDTH-1:0]       result
);
	import icalu_pkg::*;

	// A result waiting for the sink holds its value.
	`ICALU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result))

	// Only one item is in work: the input closes right after a beat.
	`ICALU_ASSERT_NEXT(a_in_close, in_valid && in_ready, !in_ready)

	// A new result is posted on the same edge that reopens the input.
	`ICALU_ASSERT_NOW(a_rise_ready, $rose(out_valid), in_ready)

	// An add taken while the output register is free posts its sum through the dispatch and done states.
	`ICALU_ASSERT_NOW(a_add_sum,
		$past(in_valid && in_ready && !out_valid && cmd == CMD_ADD, 3),
		out_valid && result == $past(operand_a, 3) + $past(operand_b, 3))

endmodule

bind integer_calculator_alu icalu_checker #(.DATA_WIDTH(DATA_WIDTH)) u_icalu_checker (.*);

// ===== tb/sv/integer_calculator_alu_checker.sv =====
`timescale 1ns / 100ps

module integer_calculator_alu_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic [icalu_pkg::CMD_W-1:0]            cmd,
	input  logic [icalu_pkg::ICALU_DATA_WIDTH-1:0] operand_a,
	input  logic [icalu_pkg::ICALU_DATA_WIDTH-1:0] operand_b,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic [icalu_pkg::ICALU_DATA_WIDTH-1:0] result,
	output int                                     mismatches,
	output int                                     outstanding
);
	import icalu_pkg::*;

	localparam int DW = ICALU_DATA_WIDTH;

	typedef struct {
		logic [CMD_W-1:0] op;
		logic [DW-1:0]    a;
		logic [DW-1:0]    b;
		logic [DW-1:0]    value;
	} alu_expect_t;

	alu_expect_t pending_results[$];

	function automatic logic [DW-1:0] alu_result(input logic [CMD_W-1:0] op,
			input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW-1:0] ma;
		logic [DW-1:0] mb;
		logic [DW-1:0] q;
		logic [DW-1:0] d;
		logic [DW-1:0] p;
		logic [DW-1:0] k;
		case (op)
			CMD_ADD:   return a + b;
			CMD_SUB:   return a - b;
			CMD_MUL:   return a * b;
			CMD_DIV: begin
				if (b == '0)
					return '0;
				ma = a[DW-1] ? -a : a;
				mb = b[DW-1] ? -b : b;
				q = ma / mb;
				return (a[DW-1] != b[DW-1]) ? -q : q;
			end
			CMD_MAX:   return ($signed(a) > $signed(b)) ? a : b;
			CMD_PRIME: begin
				// Negative values and anything below four count as prime.
				if (a[DW-1] || a < 4)
					return 1;
				for (d = 2; d <= a / d; d++) begin
					if (a % d == '0)
						return '0;
				end
				return 1;
			end
			CMD_EVEN:  return a[0] ? '0 : 1;
			CMD_SIGN: begin
				if (a == '0)
					return '1;
				return a[DW-1] ? '0 : 1;
			end
			CMD_FACT: begin
				if (a[DW-1])
					return '1;
				p = 1;
				for (k = 2; k <= a; k++) begin
					p = p * k;
					if (p == '0)
						break;
				end
				return p;
			end
			CMD_SQR:   return a * a;
			CMD_PERIM: return a << 2;
			default:   return '0;
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		alu_expect_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result beat %h with nothing expected", result));
				end else begin
					e = pending_results.pop_front();
					if (result !== e.value)
						report_mismatch($sformatf("cmd %0d a=%h b=%h: result %h, expected %h",
							e.op, e.a, e.b, result, e.value));
				end
			end
			if (in_valid && in_ready) begin
				e.op = cmd;
				e.a = operand_a;
				e.b = operand_b;
				e.value = alu_result(cmd, operand_a, operand_b);
				pending_results.push_back(e);
			end
		end
		outstanding = pending_results.size();
	end

endmodule

// ===== tb/sv/integer_calculator_alu_tb.sv =====
`timescale 1ns / 100ps

module integer_calculator_alu_tb;
	import icalu_pkg::*;

	localparam int DW = ICALU_DATA_WIDTH;
	localparam int RANDOM_PER_PHASE = 210;
	localparam int LONG_HOLD_CYCLES = 300;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [CMD_W-1:0] cmd;
	logic [DW-1:0]    operand_a;
	logic [DW-1:0]    operand_b;
	logic             out_valid;
	logic             out_ready;
	logic [DW-1:0]    result;

	int mismatches;
	int outstanding;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;

	integer_calculator_alu i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	integer_calculator_alu_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("FAILURE");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off so the block backs up.
	initial begin
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				held = 1'b1;
				repeat (LONG_HOLD_CYCLES) begin
					out_ready <= 1'b0;
					@(negedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Called right after a posedge; returns at the posedge where the beat is taken.
	task automatic send_beat(input logic [CMD_W-1:0] op, input logic [DW-1:0] a,
			input logic [DW-1:0] b);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		operand_a <= a;
		operand_b <= b;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	function automatic logic [DW-1:0] pick_operand();
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(4))
					0:       return '0;
					1:       return 1;
					2:       return '1;
					3:       return {1'b1, {(DW-1){1'b0}}};
					default: return {1'b0, {(DW-1){1'b1}}};
				endcase
			end
			1, 2: begin
				if ($urandom_range(1))
					return -DW'($urandom_range(0, 40));
				return DW'($urandom_range(0, 40));
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [CMD_W-1:0] op;
		logic [DW-1:0]    a;
		logic [DW-1:0]    b;
		int               pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = '0;
		operand_a = '0;
		operand_b = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed corners: overflow, divide special cases, prime and factorial edges, other commands and unused codes.
		send_beat(CMD_ADD, 32'h7fffffff, 32'h00000001);
		send_beat(CMD_SUB, 32'h80000000, 32'h00000001);
		send_beat(CMD_MUL, 32'h7fffffff, 32'h7fffffff);
		send_beat(CMD_MUL, -32'sd3, 32'd5);
		send_beat(CMD_DIV, 32'd100, 32'd0);
		send_beat(CMD_DIV, 32'h80000000, 32'hffffffff);
		send_beat(CMD_DIV, -32'sd7, 32'd2);
		send_beat(CMD_DIV, 32'd7, -32'sd2);
		send_beat(CMD_MAX, 32'hffffffff, 32'd1);
		send_beat(CMD_MAX, 32'h7fffffff, 32'h80000000);
		send_beat(CMD_PRIME, 32'd0, $urandom);
		send_beat(CMD_PRIME, 32'd4, $urandom);
		send_beat(CMD_PRIME, 32'd97, $urandom);
		send_beat(CMD_PRIME, -32'sd9, $urandom);
		send_beat(CMD_EVEN, 32'd0, $urandom);
		send_beat(CMD_EVEN, 32'hffffffff, $urandom);
		send_beat(CMD_SIGN, 32'd0, $urandom);
		send_beat(CMD_SIGN, 32'h80000000, $urandom);
		send_beat(CMD_FACT, 32'hffffffff, $urandom);
		send_beat(CMD_FACT, 32'd0, $urandom);
		send_beat(CMD_FACT, 32'd12, $urandom);
		send_beat(CMD_FACT, 32'd34, $urandom);
		send_beat(CMD_FACT, 32'h7fffffff, $urandom);
		send_beat(CMD_SQR, 32'h80000001, $urandom);
		send_beat(CMD_PERIM, 32'h40000001, $urandom);
		send_beat(4'(CMD_PERIM + 1), $urandom, $urandom);
		send_beat('1, $urandom, $urandom);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_request = 1'b1;
				end
				1: begin
					send_idle_pct = 75;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 75;
				end
				default: begin
					send_idle_pct = 7;
					recv_stall_pct = 7;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if ($urandom_range(19) == 0)
					op = CMD_W'($urandom_range(CMD_PERIM + 1, 15));
				else
					op = CMD_W'($urandom_range(CMD_ADD, CMD_PERIM));
				a = pick_operand();
				b = pick_operand();
				if (op == CMD_DIV && $urandom_range(7) == 0)
					b = '0;
				if (op == CMD_PRIME) begin
					// Trial division is slow, so keep most operands small.
					pick = $urandom_range(99);
					if (pick < 10)
						a = $urandom | {1'b1, {(DW-1){1'b0}}};
					else if (pick < 15)
						a = DW'($urandom_range(0, 1 << 18));
					else
						a = DW'($urandom_range(0, 4095));
				end
				send_beat(op, a, b);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
